>>> hw/rtl/mi3_pkg.sv
`default_nettype none

package mi3_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // derived widths
  localparam int PW  = 2 * ELEM_WIDTH;               // element product
  localparam int CW  = 2 * ELEM_WIDTH + 1;           // signed cofactor
  localparam int DPW = 2 * ELEM_WIDTH + 1;           // determinant partial product
  localparam int TW  = 3 * ELEM_WIDTH + 2;           // one determinant term
  localparam int DW  = 3 * ELEM_WIDTH + 4;           // determinant
  localparam int NW  = 2 * ELEM_WIDTH + 1 + 2 * FRAC_BITS;  // scaled numerator
  localparam int KW  = DW + ELEM_WIDTH - 1;          // divider compare width
  localparam int QW  = ELEM_WIDTH - 1;               // quotient magnitude bits

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t a00;
    elem_t a01;
    elem_t a02;
    elem_t a10;
    elem_t a11;
    elem_t a12;
    elem_t a20;
    elem_t a21;
    elem_t a22;
  } in_word_t;

  typedef struct packed {
    elem_t b00;
    elem_t b01;
    elem_t b02;
    elem_t b10;
    elem_t b11;
    elem_t b12;
    elem_t b20;
    elem_t b21;
    elem_t b22;
    logic  singular;
  } out_word_t;

  // one matrix handed from the determinant pipe to the divider pipe
  typedef struct packed {
    logic                sing;
    logic [DW-1:0]       dmag;
    logic [8:0]          neg;
    logic [8:0][NW-1:0]  num;
  } quo_job_t;

endpackage

`default_nettype wire

>>> hw/rtl/matrix3_inverse.sv
`default_nettype none

// channel   direction  word                 handshake
// mat       in         3x3 matrix, Q16.16   mat_valid / mat_stall
// inv       out        inverse + singular   inv_valid / inv_stall
//
// one matrix enters per cycle while mat_stall is low; the pipe holds 6 determinant
// stages, one overflow stage, ELEM_WIDTH-1 divider steps (one pipeline stage per
// quotient bit) and the output register
// every stage holds its word under stall and empty stages fill up, so a
// stall on inv reaches mat only once the whole pipe is full
// rst (synchronous) clears the valid bits only; data registers are not reset

module matrix3_inverse (
  input  logic               clk,
  input  logic               rst,
  input  logic               mat_valid,
  output logic               mat_stall,
  input  mi3_pkg::in_word_t  mat,
  output logic               inv_valid,
  input  logic               inv_stall,
  output mi3_pkg::out_word_t inv
);

  // determinant, cofactor magnitudes and signs between the two pipes
  logic              job_valid;
  logic              job_stall;
  mi3_pkg::quo_job_t job;

  // products, cofactors and determinant (six stages)
  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_valid),
    .in_stall  (mat_stall),
    .in_word   (mat),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job)
  );

  // restoring divider, one quotient bit per stage, then saturation
  mi3_quot u_quot (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .res_valid (inv_valid),
    .res_stall (inv_stall),
    .res       (inv)
  );

endmodule

`default_nettype wire

>>> hw/rtl/mi3_front.sv
`default_nettype none

module mi3_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mi3_pkg::in_word_t in_word,
  output logic              job_valid,
  input  logic              job_stall,
  output mi3_pkg::quo_job_t job
);

  localparam int E   = mi3_pkg::ELEM_WIDTH;
  localparam int PW  = mi3_pkg::PW;
  localparam int CW  = mi3_pkg::CW;
  localparam int DPW = mi3_pkg::DPW;
  localparam int TW  = mi3_pkg::TW;
  localparam int DW  = mi3_pkg::DW;
  localparam int NW  = mi3_pkg::NW;
  localparam int F   = mi3_pkg::FRAC_BITS;

  // cofactor i = p*s - q*t, negated where NEGC is set (i = 3r+c of the result)
  localparam int OPP [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int OPS [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam int OPQ [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  localparam int OPT [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
  localparam logic [8:0] NEGC = 9'b010101010;

  mi3_pkg::elem_t a [9];
  assign a[0] = in_word.a00;
  assign a[1] = in_word.a01;
  assign a[2] = in_word.a02;
  assign a[3] = in_word.a10;
  assign a[4] = in_word.a11;
  assign a[5] = in_word.a12;
  assign a[6] = in_word.a20;
  assign a[7] = in_word.a21;
  assign a[8] = in_word.a22;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  logic signed [PW-1:0]  px1 [9];
  logic signed [PW-1:0]  py1 [9];
  mi3_pkg::elem_t        ad1 [3];
  logic signed [CW-1:0]  c2  [9];
  mi3_pkg::elem_t        ad2 [3];
  logic signed [DPW-1:0] lo3 [3];
  logic signed [DPW-1:0] hi3 [3];
  logic signed [CW-1:0]  c3  [9];
  logic signed [TW-1:0]  t4  [3];
  logic signed [CW-1:0]  c4  [9];
  logic signed [DW-1:0]  d5;
  logic signed [CW-1:0]  c5  [9];

  mi3_pkg::quo_job_t job_next;

  assign rdy6 = !job_valid || !job_stall;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) job_valid <= v5;
    end
  end

  // element products
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 9; i++) begin
        px1[i] <= a[OPP[i]] * a[OPS[i]];
        py1[i] <= a[OPQ[i]] * a[OPT[i]];
      end
      ad1[0] <= a[0];
      ad1[1] <= a[3];
      ad1[2] <= a[6];
    end
  end

  // signed cofactors
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < 9; i++) begin
        c2[i] <= NEGC[i] ? (CW'(py1[i]) - CW'(px1[i])) : (CW'(px1[i]) - CW'(py1[i]));
      end
      ad2 <= ad1;
    end
  end

  // determinant partial products, cofactor split into low and high halves
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int j = 0; j < 3; j++) begin
        lo3[j] <= ad2[j] * $signed({1'b0, c2[j][E-1:0]});
        hi3[j] <= ad2[j] * $signed(c2[j][CW-1:E]);
      end
      c3 <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int j = 0; j < 3; j++) begin
        t4[j] <= (TW'(hi3[j]) <<< E) + TW'(lo3[j]);
      end
      c4 <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      d5 <= DW'(t4[0]) + DW'(t4[1]) + DW'(t4[2]);
      c5 <= c4;
    end
  end

  // magnitudes and signs for the divider
  always_comb begin
    logic [CW-1:0] cm;
    job_next.sing = (d5 == '0);
    job_next.dmag = d5[DW-1] ? DW'(-d5) : DW'(d5);
    for (int i = 0; i < 9; i++) begin
      cm = c5[i][CW-1] ? CW'(-c5[i]) : CW'(c5[i]);
      job_next.neg[i] = c5[i][CW-1] ^ d5[DW-1];
      job_next.num[i] = NW'(cm) << (2 * F);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      job <= job_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mi3_quot.sv
`default_nettype none

module mi3_quot (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_stall,
  input  mi3_pkg::quo_job_t  job,
  output logic               res_valid,
  input  logic               res_stall,
  output mi3_pkg::out_word_t res
);

  localparam int E  = mi3_pkg::ELEM_WIDTH;
  localparam int DW = mi3_pkg::DW;
  localparam int NW = mi3_pkg::NW;
  localparam int KW = mi3_pkg::KW;
  localparam int QW = mi3_pkg::QW;

  typedef struct packed {
    logic               sing;
    logic [8:0]         neg;
    logic [8:0]         sat;
    logic [DW-1:0]      dmag;
    logic [8:0][NW-1:0] rem;
    logic [8:0][QW-1:0] quo;
  } div_st_t;

  div_st_t    st [E];
  logic [E-1:0] v;
  logic [E:0]   rdy;

  assign rdy[E]    = !res_valid || !res_stall;
  assign job_stall = !rdy[0];

  for (genvar j = 0; j < E; j++) begin : g_st
    div_st_t nx;
    logic    vin;

    assign rdy[j] = !v[j] || rdy[j+1];

    if (j == 0) begin : g_ovf
      // quotient of 2^(E-1) or more saturates
      assign vin = job_valid;
      always_comb begin
        nx.sing = job.sing;
        nx.neg  = job.neg;
        nx.dmag = job.dmag;
        nx.rem  = job.num;
        nx.quo  = '0;
        for (int i = 0; i < 9; i++) begin
          nx.sat[i] = KW'(job.num[i]) >= (KW'(job.dmag) << (E - 1));
        end
      end
    end else begin : g_bit
      // one restoring step, quotient bit K
      localparam int K = E - 1 - j;
      logic [KW-1:0] sh;
      assign vin = v[j-1];
      assign sh  = KW'(st[j-1].dmag) << K;
      always_comb begin
        nx = st[j-1];
        for (int i = 0; i < 9; i++) begin
          if (!st[j-1].sat[i] && (KW'(st[j-1].rem[i]) >= sh)) begin
            nx.rem[i]    = NW'(KW'(st[j-1].rem[i]) - sh);
            nx.quo[i][K] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        st[j] <= nx;
      end
    end
  end

  // sign, saturation and singular override
  mi3_pkg::elem_t    bv [9];
  mi3_pkg::out_word_t res_next;

  always_comb begin
    logic [E-1:0] mag;
    for (int i = 0; i < 9; i++) begin
      mag = {1'b0, st[E-1].quo[i]};
      if (st[E-1].sing) begin
        bv[i] = '0;
      end else if (st[E-1].sat[i]) begin
        bv[i] = st[E-1].neg[i] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
      end else begin
        bv[i] = st[E-1].neg[i] ? -mag : mag;
      end
    end
    res_next.b00      = bv[0];
    res_next.b01      = bv[1];
    res_next.b02      = bv[2];
    res_next.b10      = bv[3];
    res_next.b11      = bv[4];
    res_next.b12      = bv[5];
    res_next.b20      = bv[6];
    res_next.b21      = bv[7];
    res_next.b22      = bv[8];
    res_next.singular = st[E-1].sing;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rdy[E]) begin
      res_valid <= v[E-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[E]) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mi3_check.sv
`default_nettype none

module mi3_check (
  input logic               clk,
  input logic               rst,
  input logic               mat_valid,
  input logic               mat_stall,
  input mi3_pkg::in_word_t  mat,
  input logic               inv_valid,
  input logic               inv_stall,
  input mi3_pkg::out_word_t inv
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !inv_valid)
    else $error("word out right after reset");

  // a free output side never backs up the input
  a_no_false_stall: assert property (@(posedge clk) !inv_stall |-> !mat_stall)
    else $error("input stalled while output free");

  // singular words carry an all-zero inverse
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv.singular |->
      inv.b00 == '0 && inv.b01 == '0 && inv.b02 == '0 &&
      inv.b10 == '0 && inv.b11 == '0 && inv.b12 == '0 &&
      inv.b20 == '0 && inv.b21 == '0 && inv.b22 == '0)
    else $error("singular word with nonzero data");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv_stall |=> inv_valid)
    else $error("output word dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv_stall |=> $stable(inv))
    else $error("output word changed under stall");

endmodule

bind matrix3_inverse mi3_check u_check (.*);

`default_nettype wire
